// ===== hw/rtl/arnp_pkg.sv =====
package arnp_pkg;

    localparam int MAX_LEN_DEF = 32;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_ONE   = 8'd49;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_UC_A  = 8'd65;
    localparam logic [7:0] CH_UC_B  = 8'd66;
    localparam logic [7:0] CH_UC_F  = 8'd70;
    localparam logic [7:0] CH_UC_X  = 8'd88;
    localparam logic [7:0] CH_LC_A  = 8'd97;
    localparam logic [7:0] CH_LC_B  = 8'd98;
    localparam logic [7:0] CH_LC_F  = 8'd102;
    localparam logic [7:0] CH_LC_X  = 8'd120;
    localparam logic [7:0] IDX_LAST = 8'd255;

    typedef enum logic [1:0] {
        MODE_DEC = 2'd0,
        MODE_HEX = 2'd1,
        MODE_BIN = 2'd2
    } t_mode;

    typedef struct packed {
        logic [31:0] acc;
        logic [7:0]  first;
        logic [7:0]  idx;
        t_mode       mode;
        logic        neg;
        logic        bad;
    } t_tok;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    function automatic t_digit digit_of(input logic [7:0] c, input t_mode mode);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (mode == MODE_BIN) begin
            if (c == CH_ZERO || c == CH_ONE) begin
                d.ok  = 1'b1;
                d.val = 4'(c - CH_ZERO);
            end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_ZERO);
        end else if (mode == MODE_HEX) begin
            if (c >= CH_LC_A && c <= CH_LC_F) begin
                d.ok  = 1'b1;
                d.val = 4'(c - CH_LC_A) + 4'd10;
            end else if (c >= CH_UC_A && c <= CH_UC_F) begin
                d.ok  = 1'b1;
                d.val = 4'(c - CH_UC_A) + 4'd10;
            end
        end
        return d;
    endfunction

endpackage

// ===== hw/rtl/arnp_core.sv =====
module arnp_core #(
    parameter int MaxLen = arnp_pkg::MAX_LEN_DEF
) (
    input  arnp_pkg::t_tok i_tok,
    input  logic [7:0]     i_character,
    input  logic           i_missing_arg,
    output arnp_pkg::t_tok o_tok,
    output logic           o_res,
    output logic [31:0]    o_value,
    output logic           o_invalid
);

    localparam logic [7:0] LP_MAX = 8'(MaxLen);

    function automatic arnp_pkg::t_tok dec_first(input arnp_pkg::t_tok s);
        arnp_pkg::t_tok t;
        arnp_pkg::t_digit d;
        t = s;
        t.mode = arnp_pkg::MODE_DEC;
        d = arnp_pkg::digit_of(s.first, arnp_pkg::MODE_DEC);
        if (s.first == arnp_pkg::CH_MINUS) begin
            t.neg = 1'b1;
        end else if (!d.ok) begin
            t.bad = 1'b1;
        end else begin
            t.acc = {28'd0, d.val};
        end
        return t;
    endfunction

    function automatic arnp_pkg::t_tok feed(input arnp_pkg::t_tok s, input logic [7:0] c);
        arnp_pkg::t_tok t;
        arnp_pkg::t_digit d;
        logic [31:0] scaled;
        t = s;
        d = arnp_pkg::digit_of(c, s.mode);
        unique case (s.mode)
            arnp_pkg::MODE_HEX: scaled = {s.acc[27:0], 4'd0};
            arnp_pkg::MODE_BIN: scaled = {s.acc[30:0], 1'b0};
            default:            scaled = {s.acc[28:0], 3'd0} + {s.acc[30:0], 1'b0};
        endcase
        if (!d.ok) begin
            t.bad = 1'b1;
        end else begin
            t.acc = scaled + {28'd0, d.val};
        end
        return t;
    endfunction

    arnp_pkg::t_tok w_end;
    arnp_pkg::t_tok w_mid;

    always_comb begin
        o_tok     = i_tok;
        o_res     = 1'b0;
        o_value   = 32'd0;
        o_invalid = 1'b0;
        w_end     = i_tok;
        w_mid     = i_tok;
        if (i_missing_arg) begin
            o_res     = 1'b1;
            o_invalid = 1'b1;
            o_tok     = '0;
        end else if (i_character == arnp_pkg::CH_NUL) begin
            if (i_tok.idx == 8'd1 && !i_tok.bad) begin
                w_end = dec_first(i_tok);
            end
            o_res     = 1'b1;
            o_invalid = w_end.bad;
            if (w_end.bad) begin
                o_value = 32'd0;
            end else if (w_end.neg && w_end.mode != arnp_pkg::MODE_HEX
                         && w_end.mode != arnp_pkg::MODE_BIN) begin
                o_value = 32'd0 - w_end.acc;
            end else begin
                o_value = w_end.acc;
            end
            o_tok = '0;
        end else if (i_tok.idx < LP_MAX && !i_tok.bad) begin
            if (i_tok.idx == 8'd0) begin
                w_mid.first = i_character;
            end else if (i_tok.idx == 8'd1) begin
                if (i_character == arnp_pkg::CH_LC_X || i_character == arnp_pkg::CH_UC_X) begin
                    w_mid.mode = arnp_pkg::MODE_HEX;
                    w_mid.acc  = 32'd0;
                end else if (i_character == arnp_pkg::CH_LC_B
                             || i_character == arnp_pkg::CH_UC_B) begin
                    w_mid.mode = arnp_pkg::MODE_BIN;
                    w_mid.acc  = 32'd0;
                end else begin
                    w_mid = dec_first(i_tok);
                    if (!w_mid.bad) begin
                        w_mid = feed(w_mid, i_character);
                    end
                end
            end else begin
                w_mid = feed(i_tok, i_character);
            end
            if (i_tok.idx != arnp_pkg::IDX_LAST) begin
                w_mid.idx = i_tok.idx + 8'd1;
            end
            o_tok = w_mid;
        end
    end

endmodule

// ===== hw/rtl/ascii_radix_number_parser.sv =====
// ASCII number parser: feed one token byte per request, ended by a NUL byte; the NUL request
// (or any request with i_missing_arg set) yields one result. A second byte of x/X or b/B selects
// hex or binary and the first byte is ignored; otherwise the token is decimal with an optional
// leading minus. A bad digit gives value 0 with o_invalid set; bytes at or past MaxLen are ignored;
// the 32-bit value wraps. One request per cycle is taken unless o_stall is high (a result waits
// on a held output): each passes an input register, one shift-and-add step and a result register.
module ascii_radix_number_parser #(
    parameter int MaxLen = arnp_pkg::MAX_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_character,
    input  logic               i_missing_arg,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value,
    output logic               o_invalid
);

    logic           r_in_vld;
    logic [7:0]     r_char;
    logic           r_miss;
    arnp_pkg::t_tok r_tok;
    logic           r_out_vld;
    logic [31:0]    r_value;
    logic           r_invalid;

    arnp_pkg::t_tok n_tok;
    logic           w_res;
    logic [31:0]    w_value;
    logic           w_invalid;
    logic           w_out_free;
    logic           w_adv;

    arnp_core #(
        .MaxLen (MaxLen)
    ) u_core (
        .i_tok         (r_tok),
        .i_character   (r_char),
        .i_missing_arg (r_miss),
        .o_tok         (n_tok),
        .o_res         (w_res),
        .o_value       (w_value),
        .o_invalid     (w_invalid)
    );

    assign w_out_free = !r_out_vld || !i_stall;
    assign w_adv      = r_in_vld && (!w_res || w_out_free);
    assign o_stall    = r_in_vld && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_tok     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (w_adv) begin
                r_tok <= n_tok;
            end
            if (w_out_free) begin
                r_out_vld <= w_adv && w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_char <= i_character;
            r_miss <= i_missing_arg;
        end
        if (w_out_free && w_adv && w_res) begin
            r_value   <= w_value;
            r_invalid <= w_invalid;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_value   = signed'(r_value);
    assign o_invalid = r_invalid;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    localparam int TOKEN_LIMIT = arnp_pkg::MAX_LEN_DEF;
    localparam int RANDOM_REQS = 1550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic [7:0] code;
        logic       missing;
        logic       wait_idle;
    } t_parser_req;

    typedef struct packed {
        logic [31:0] value;
        logic        invalid;
    } t_parse_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_character = 8'd0;
    logic               i_missing_arg = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_value;
    logic               o_invalid;

    t_parser_req   pending_chars[$];
    t_parse_result pending_results[$];

    logic [31:0]     tok_acc;
    logic [7:0]      tok_first;
    logic [7:0]      tok_idx;
    arnp_pkg::t_mode tok_mode;
    logic            tok_neg;
    logic            tok_bad;

    bit drain_first = 1'b0;
    bit req_taken = 1'b0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int reqs_taken = 0;
    int results_seen = 0;
    int invalid_results = 0;
    int dec_tokens = 0;
    int hex_tokens = 0;
    int bin_tokens = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_left = 0;

    ascii_radix_number_parser #(
        .MaxLen(TOKEN_LIMIT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_character  (i_character),
        .i_missing_arg(i_missing_arg),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .o_invalid    (o_invalid)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        end
    endtask

    function automatic logic [4:0] digit_code(input logic [7:0] ch, input arnp_pkg::t_mode mode);
        logic [4:0] code;
        code = 5'd0;
        if (mode == arnp_pkg::MODE_BIN) begin
            if (ch == arnp_pkg::CH_ZERO || ch == arnp_pkg::CH_ONE) begin
                code = {1'b1, 4'(ch - arnp_pkg::CH_ZERO)};
            end
        end else if (ch >= arnp_pkg::CH_ZERO && ch <= arnp_pkg::CH_NINE) begin
            code = {1'b1, 4'(ch - arnp_pkg::CH_ZERO)};
        end else if (mode == arnp_pkg::MODE_HEX && ch >= arnp_pkg::CH_LC_A
                     && ch <= arnp_pkg::CH_LC_F) begin
            code = {1'b1, 4'(ch - arnp_pkg::CH_LC_A + 8'd10)};
        end else if (mode == arnp_pkg::MODE_HEX && ch >= arnp_pkg::CH_UC_A
                     && ch <= arnp_pkg::CH_UC_F) begin
            code = {1'b1, 4'(ch - arnp_pkg::CH_UC_A + 8'd10)};
        end
        return code;
    endfunction

    task automatic restart_token();
        tok_acc   = 32'd0;
        tok_first = 8'd0;
        tok_idx   = 8'd0;
        tok_mode  = arnp_pkg::MODE_DEC;
        tok_neg   = 1'b0;
        tok_bad   = 1'b0;
    endtask

    task automatic take_accum_digit(input logic [7:0] ch);
        logic [4:0]  code;
        logic [31:0] base;
        code = digit_code(ch, tok_mode);
        base = (tok_mode == arnp_pkg::MODE_HEX) ? 32'd16 :
               (tok_mode == arnp_pkg::MODE_BIN) ? 32'd2 : 32'd10;
        if (!code[4]) tok_bad = 1'b1;
        else tok_acc = tok_acc * base + 32'(code[3:0]);
    endtask

    task automatic settle_decimal_lead();
        logic [4:0] code;
        tok_mode = arnp_pkg::MODE_DEC;
        if (tok_first == arnp_pkg::CH_MINUS) begin
            tok_neg = 1'b1;
        end else begin
            code = digit_code(tok_first, arnp_pkg::MODE_DEC);
            if (!code[4]) tok_bad = 1'b1;
            else tok_acc = 32'(code[3:0]);
        end
    endtask

    task automatic parse_request(input logic [7:0] ch, input logic miss,
                                 output bit emits, output t_parse_result res);
        emits = 1'b0;
        res.value = 32'd0;
        res.invalid = 1'b0;
        if (miss) begin
            emits = 1'b1;
            res.invalid = 1'b1;
            restart_token();
        end else if (ch == arnp_pkg::CH_NUL) begin
            if (tok_idx == 8'd1 && !tok_bad) settle_decimal_lead();
            emits = 1'b1;
            res.invalid = tok_bad;
            if (tok_bad) res.value = 32'd0;
            else if (tok_neg && tok_mode == arnp_pkg::MODE_DEC) res.value = 32'd0 - tok_acc;
            else res.value = tok_acc;
            case (tok_mode)
                arnp_pkg::MODE_HEX: hex_tokens++;
                arnp_pkg::MODE_BIN: bin_tokens++;
                default:            dec_tokens++;
            endcase
            restart_token();
        end else if (tok_idx < TOKEN_LIMIT && !tok_bad) begin
            if (tok_idx == 8'd0) begin
                tok_first = ch;
            end else if (tok_idx == 8'd1) begin
                if (ch == arnp_pkg::CH_LC_X || ch == arnp_pkg::CH_UC_X) begin
                    tok_mode = arnp_pkg::MODE_HEX;
                    tok_acc = 32'd0;
                end else if (ch == arnp_pkg::CH_LC_B || ch == arnp_pkg::CH_UC_B) begin
                    tok_mode = arnp_pkg::MODE_BIN;
                    tok_acc = 32'd0;
                end else begin
                    settle_decimal_lead();
                    if (!tok_bad) take_accum_digit(ch);
                end
            end else begin
                take_accum_digit(ch);
            end
            if (tok_idx != arnp_pkg::IDX_LAST) tok_idx = tok_idx + 8'd1;
        end
    endtask

    task automatic queue_request(input logic [7:0] ch, input logic miss);
        pending_chars.push_back('{code: ch, missing: miss, wait_idle: drain_first});
        drain_first = 1'b0;
    endtask

    task automatic queue_token(input string s);
        for (int i = 0; i < s.len(); i++) queue_request(s[i], 1'b0);
        queue_request(arnp_pkg::CH_NUL, 1'b0);
    endtask

    function automatic logic [7:0] random_digit(input arnp_pkg::t_mode mode);
        int pick;
        pick = (mode == arnp_pkg::MODE_HEX) ? $urandom_range(0, 21) :
               (mode == arnp_pkg::MODE_BIN) ? $urandom_range(0, 1) : $urandom_range(0, 9);
        if (pick < 10) return arnp_pkg::CH_ZERO + 8'(pick);
        if (pick < 16) return arnp_pkg::CH_LC_A + 8'(pick - 10);
        return arnp_pkg::CH_UC_A + 8'(pick - 16);
    endfunction

    function automatic int digits_count();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    endfunction

    task automatic queue_random_token();
        logic [7:0] tok[$];
        int kind;
        int n;
        int cut;
        kind = $urandom_range(0, 99);
        n = digits_count();
        if (kind < 45) begin
            if ($urandom_range(0, 3) == 0) tok.push_back(arnp_pkg::CH_MINUS);
            repeat (n) tok.push_back(random_digit(arnp_pkg::MODE_DEC));
        end else if (kind < 75) begin
            tok.push_back(8'($urandom_range(1, 255)));
            tok.push_back($urandom_range(0, 1) ? arnp_pkg::CH_LC_X : arnp_pkg::CH_UC_X);
            repeat (n) tok.push_back(random_digit(arnp_pkg::MODE_HEX));
        end else if (kind < 92) begin
            tok.push_back(8'($urandom_range(1, 255)));
            tok.push_back($urandom_range(0, 1) ? arnp_pkg::CH_LC_B : arnp_pkg::CH_UC_B);
            repeat (n) tok.push_back(random_digit(arnp_pkg::MODE_BIN));
        end else begin
            repeat ($urandom_range(0, 6)) tok.push_back(8'($urandom_range(1, 255)));
        end
        if (tok.size() > 0 && $urandom_range(0, 9) == 0) begin
            tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 19) == 0) begin
            cut = $urandom_range(0, tok.size());
            for (int i = 0; i < cut; i++) queue_request(tok[i], 1'b0);
            queue_request(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            foreach (tok[i]) queue_request(tok[i], 1'b0);
            queue_request(arnp_pkg::CH_NUL, 1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ascii_radix_number_parser verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        bit            emits;
        t_parse_result res;
        t_parse_result want;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                req_taken = 1'b1;
                reqs_taken++;
                parse_request(i_character, i_missing_arg, emits, res);
                if (emits) pending_results.push_back(res);
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (o_invalid === 1'b1) invalid_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: value %0d invalid %0b",
                                              o_value, o_invalid));
                end else begin
                    want = pending_results.pop_front();
                    if (o_value !== want.value || o_invalid !== want.invalid) begin
                        report_mismatch($sformatf("value %0d expected %0d, invalid %0b expected %0b",
                                                  o_value, $signed(want.value), o_invalid,
                                                  want.invalid));
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        t_parser_req next_req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_chars.size() > 0 &&
                         !(pending_chars[0].wait_idle && pending_results.size() != 0)) begin
                next_req = pending_chars.pop_front();
                i_character <= next_req.code;
                i_missing_arg <= next_req.missing;
                i_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 20)
                                                           : $urandom_range(1, 4);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        case ((cycle_count >> 8) % 4)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 2) == 0);
            2: i_stall <= ((cycle_count % 7) < 3);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                    if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
                end
            end
        endcase
    end

    initial begin
        int random_start;
        restart_token();

        queue_token("");
        queue_request(8'hFF, 1'b1);
        queue_token("-");
        queue_token("0x");
        queue_token("0b");
        queue_request(arnp_pkg::CH_NINE, 1'b0);
        queue_request(arnp_pkg::CH_NUL, 1'b1);
        queue_request(8'hFF, 1'b0);
        queue_token("XfA");
        queue_token("Zb101");
        drain_first = 1'b1;
        queue_token("5-");

        random_start = pending_chars.size();
        drain_first = 1'b1;
        while (pending_chars.size() - random_start < RANDOM_REQS) begin
            if ($urandom_range(0, 39) == 0) drain_first = 1'b1;
            queue_random_token();
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || i_valid) @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("Run covered %0d requests and %0d results (%0d flagged invalid)",
                 reqs_taken, results_seen, invalid_results);
        $display("Tokens ended in decimal %0d, hex %0d, binary %0d; mismatches %0d",
                 dec_tokens, hex_tokens, bin_tokens, mismatch_count);
        if (mismatch_count == 0) begin
            $display("ascii_radix_number_parser verification clean");
        end else begin
            $display("ascii_radix_number_parser verification failed");
        end
        $finish;
    end

endmodule
